FILE: rtl/npcm_pkg.sv
// Shared types, codes and constants of the nearest palette color mapper.
package npcm_pkg;

  localparam int unsigned FIXED_ENTRIES_DEF = 256;
  localparam int unsigned NEW_ENTRIES_DEF   = 256;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned DIST_W            = 18;

  localparam logic [1:0] OP_WR_FIX = 2'd0;
  localparam logic [1:0] OP_WR_NEW = 2'd1;
  localparam logic [1:0] OP_MAP    = 2'd2;

  localparam logic [1:0] REG_FIX_LO    = 2'd0;
  localparam logic [1:0] REG_FIX_HI    = 2'd1;
  localparam logic [1:0] REG_PAL_BASE  = 2'd2;
  localparam logic [1:0] REG_PAL_COUNT = 2'd3;

  typedef enum logic [1:0] {
    CMD_WR_FIX = 2'd0,
    CMD_WR_NEW = 2'd1,
    CMD_MAP    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] fix_lo;
    logic [7:0] fix_hi;
    logic [7:0] pal_base;
    logic [8:0] pal_count;
  } cfg_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/npcm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module npcm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/npcm_front.sv
// Input side: decodes each word, drops ignored ones and queues the commands.
module npcm_front
  import npcm_pkg::*;
#(
  parameter int unsigned FIXED_ENTRIES = FIXED_ENTRIES_DEF,
  parameter int unsigned NEW_ENTRIES   = NEW_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_op,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_last_pixel,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_pop
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           keep;
  logic           enq;
  logic           deq;
  cmd_t           new_cmd;

  always_comb begin
    new_cmd.idx   = in_entry_index;
    new_cmd.red   = in_red;
    new_cmd.green = in_green;
    new_cmd.blue  = in_blue;
    new_cmd.last  = in_last_pixel;
    new_cmd.kind  = CMD_MAP;
    keep          = 1'b0;
    case (in_op)
      OP_WR_FIX: begin
        new_cmd.kind = CMD_WR_FIX;
        keep = ({1'b0, in_entry_index} < 9'(FIXED_ENTRIES));
      end
      OP_WR_NEW: begin
        new_cmd.kind = CMD_WR_NEW;
        keep = ({1'b0, in_entry_index} < 9'(NEW_ENTRIES));
      end
      OP_MAP: begin
        new_cmd.kind = CMD_MAP;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count_r == QCW'(QUEUE_DEPTH));
  assign enq       = push && !full && keep;
  assign cmd_valid = (count_r != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (enq && !deq) begin
        count_r <= count_r + 1'b1;
      end else if (deq && !enq) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/npcm_search.sv
// Back side: executes table writes and sweeps candidates for each mapped pixel.
module npcm_search
  import npcm_pkg::*;
#(
  parameter int unsigned FIXED_ENTRIES = FIXED_ENTRIES_DEF,
  parameter int unsigned NEW_ENTRIES   = NEW_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_color_index,
  output logic       out_end_of_image
);

  localparam int unsigned FIX_AW = (FIXED_ENTRIES > 1) ? $clog2(FIXED_ENTRIES) : 1;
  localparam int unsigned NEW_AW = (NEW_ENTRIES > 1) ? $clog2(NEW_ENTRIES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIX   = 4'b0010,
    ST_NEW   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        k_r, k_nxt;
  logic [7:0]        pr_r, pg_r, pb_r;
  logic              plast_r;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [7:0]        best_r, best_nxt;
  logic              s1_v_r, s1_new_r;
  logic [7:0]        s1_tag_r;
  logic              s2_v_r;
  logic [7:0]        s2_tag_r;
  logic [15:0]       s2_sqr_r, s2_sqg_r, s2_sqb_r;
  logic              out_v_r;
  logic [7:0]        out_idx_r;
  logic              out_eoi_r;

  logic [7:0]        hi_c;
  logic [8:0]        count_c;
  logic              fix_any;
  logic              new_any;
  logic              fix_we, new_we;
  logic [23:0]       wr_color;
  logic [23:0]       fix_rdata, new_rdata, ent;
  logic [7:0]        adr, adg, adb;
  logic [DIST_W-1:0] dsum;
  logic              start_map;
  logic              out_load;

  assign hi_c    = ({1'b0, cfg.fix_hi} > 9'(FIXED_ENTRIES - 1)) ? 8'(FIXED_ENTRIES - 1)
                                                                 : cfg.fix_hi;
  assign count_c = (cfg.pal_count > 9'(NEW_ENTRIES)) ? 9'(NEW_ENTRIES) : cfg.pal_count;
  assign fix_any = (cfg.fix_lo <= hi_c);
  assign new_any = (count_c != 9'd0);

  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign fix_we    = cmd_pop && (cmd.kind == CMD_WR_FIX);
  assign new_we    = cmd_pop && (cmd.kind == CMD_WR_NEW);
  assign start_map = cmd_pop && (cmd.kind == CMD_MAP);
  assign wr_color  = {cmd.red, cmd.green, cmd.blue};

  npcm_ram #(.WIDTH(24), .DEPTH(FIXED_ENTRIES)) u_fix_ram (
    .clk     (clk),
    .wr_en   (fix_we),
    .wr_addr (cmd.idx[FIX_AW-1:0]),
    .wr_data (wr_color),
    .rd_addr (k_r[FIX_AW-1:0]),
    .rd_data (fix_rdata)
  );

  npcm_ram #(.WIDTH(24), .DEPTH(NEW_ENTRIES)) u_new_ram (
    .clk     (clk),
    .wr_en   (new_we),
    .wr_addr (cmd.idx[NEW_AW-1:0]),
    .wr_data (wr_color),
    .rd_addr (k_r[NEW_AW-1:0]),
    .rd_data (new_rdata)
  );

  assign ent  = s1_new_r ? new_rdata : fix_rdata;
  assign adr  = abs_diff(pr_r, ent[23:16]);
  assign adg  = abs_diff(pg_r, ent[15:8]);
  assign adb  = abs_diff(pb_r, ent[7:0]);
  assign dsum = DIST_W'(s2_sqr_r) + DIST_W'(s2_sqg_r) + DIST_W'(s2_sqb_r);

  assign out_load = (state_r == ST_DRAIN) && !s1_v_r && !s2_v_r && (!out_v_r || pop);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    best_d_nxt = best_d_r;
    best_nxt   = best_r;
    if (s2_v_r && (dsum < best_d_r)) begin
      best_d_nxt = dsum;
      best_nxt   = s2_tag_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (start_map) begin
          best_d_nxt = '1;
          best_nxt   = cfg.pal_base;
          if (fix_any) begin
            k_nxt     = cfg.fix_lo;
            state_nxt = ST_FIX;
          end else if (new_any) begin
            k_nxt     = 8'd0;
            state_nxt = ST_NEW;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_FIX: begin
        if (k_r == hi_c) begin
          k_nxt     = 8'd0;
          state_nxt = new_any ? ST_NEW : ST_DRAIN;
        end else begin
          k_nxt = k_r + 8'd1;
        end
      end
      ST_NEW: begin
        if ({1'b0, k_r} == count_c - 9'd1) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 8'd1;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    best_d_r <= best_d_nxt;
    best_r   <= best_nxt;
    if (start_map) begin
      pr_r    <= cmd.red;
      pg_r    <= cmd.green;
      pb_r    <= cmd.blue;
      plast_r <= cmd.last;
    end
    s1_new_r <= (state_r == ST_NEW);
    s1_tag_r <= (state_r == ST_NEW) ? (cfg.pal_base + k_r) : k_r;
    s2_tag_r <= s1_tag_r;
    s2_sqr_r <= {8'd0, adr} * {8'd0, adr};
    s2_sqg_r <= {8'd0, adg} * {8'd0, adg};
    s2_sqb_r <= {8'd0, adb} * {8'd0, adb};
    if (out_load) begin
      out_idx_r <= best_r;
      out_eoi_r <= plast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == ST_FIX) || (state_r == ST_NEW);
      s2_v_r  <= s1_v_r;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign empty            = !out_v_r;
  assign out_color_index  = out_idx_r;
  assign out_end_of_image = out_eoi_r;

endmodule

FILE: rtl/nearest_palette_color_mapper.sv
// Top level of the nearest palette color mapper: configuration registers and the two halves.
// A table write is executed by the search engine after passing the four-entry input queue.
// A mapped pixel sweeps its F fixed and then its N new candidates in the search engine,
// or goes straight to draining when there is no candidate; its result leaves through the output register.
// Reset restores the registers to their defaults and empties the queue and result register.
// Palette RAMs are not cleared and hold unknown data until written.
module nearest_palette_color_mapper
  import npcm_pkg::*;
#(
  parameter int unsigned FIXED_ENTRIES = FIXED_ENTRIES_DEF,
  parameter int unsigned NEW_ENTRIES   = NEW_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_op,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_last_pixel,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_color_index,
  output logic       out_end_of_image,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fix_lo    <= 8'd0;
      cfg_r.fix_hi    <= 8'd255;
      cfg_r.pal_base  <= 8'd0;
      cfg_r.pal_count <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIX_LO:    cfg_r.fix_lo    <= cfg_wdata[7:0];
        REG_FIX_HI:    cfg_r.fix_hi    <= cfg_wdata[7:0];
        REG_PAL_BASE:  cfg_r.pal_base  <= cfg_wdata[7:0];
        REG_PAL_COUNT: cfg_r.pal_count <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  npcm_front #(
    .FIXED_ENTRIES (FIXED_ENTRIES),
    .NEW_ENTRIES   (NEW_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_last_pixel  (in_last_pixel),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop)
  );

  npcm_search #(
    .FIXED_ENTRIES (FIXED_ENTRIES),
    .NEW_ENTRIES   (NEW_ENTRIES)
  ) u_search (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .cmd_valid        (cmd_valid),
    .cmd_pop          (cmd_pop),
    .empty            (empty),
    .pop              (pop),
    .out_color_index  (out_color_index),
    .out_end_of_image (out_end_of_image)
  );

endmodule
